FILE: hdl/nfha_pkg.sv
`timescale 1ns / 1ps
package nfha_pkg;

	// request actions
	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_LOCK    = 2'd2;
	localparam logic [1:0] ACT_CHECK   = 2'd3;

	// result status codes
	localparam logic [1:0] ST_SUCCESS    = 2'd0;
	localparam logic [1:0] ST_NO_MORE    = 2'd1;
	localparam logic [1:0] ST_BAD_HANDLE = 2'd2;
	localparam logic [1:0] ST_LOCKED     = 2'd3;

	// find-first tree: slots per group and the index width inside a group
	localparam int GROUP_BITS = 16;
	localparam int GROUP_IW   = 4;

	localparam int HANDLE_IN_W  = 8;
	localparam int HANDLE_OUT_W = 7;

	// controller to datapath commands
	typedef struct packed {
		logic capture;  // latch the request, read the lock bit
		logic search;   // register per-group free summaries
		logic commit;   // update the table and present the result
	} nfha_cmd_t;

endpackage

FILE: hdl/next_fit_handle_allocator_core.sv
`timescale 1ns / 1ps
// Next-fit handle allocator. A table of TABLE_ENTRIES slots holds an in-use
// bit and a lock bit per slot, and a pointer marks where the next allocate
// starts its circular search. Raise start with action and handle_in while
// busy is low; the request is taken at that clock edge and busy rises. Every
// request gives exactly one result: done pulses for a single cycle with status
// and handle_out, and the receiver must take it then, since nothing holds the
// result. An allocate passes through capture, a register of the per-group
// free summaries of a two-level find-first tree, and the pick of the
// winner with the commit; release, lock and check skip the search and go
// straight from capture to commit. busy drops in the same cycle the result
// shows, so a new request is taken then, and not before the last result
// is out. After reset every slot is free and the pointer is zero; no
// clearing pass is needed. handle_out is the granted slot truncated to 7
// bits and zero on anything but a successful allocate.
module next_fit_handle_allocator_core
	import nfha_pkg::*;
#(
	parameter int TABLE_ENTRIES = 128
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              action,
	input  logic [HANDLE_IN_W-1:0]  handle_in,
	output logic                    done,
	output logic [1:0]              status,
	output logic [HANDLE_OUT_W-1:0] handle_out
);

	// commands from the sequencer to the table datapath
	nfha_cmd_t cmd;

	// sequencer: idle, search (allocate only), commit
	nfha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.action (action),
		.busy   (busy),
		.cmd    (cmd)
	);

	// slot table, lock memory, next-fit pointer, find-first tree, result regs
	nfha_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.action     (action),
		.handle_in  (handle_in),
		.done       (done),
		.status     (status),
		.handle_out (handle_out)
	);

endmodule

FILE: hdl/nfha_ctrl.sv
`timescale 1ns / 1ps
module nfha_ctrl
	import nfha_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] action,
	output logic       busy,
	output nfha_cmd_t  cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (action == ACT_ALLOC) ? S_SEARCH : S_COMMIT;
				end
			end
			S_SEARCH: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.capture = accept;
	assign cmd.search  = (state_q == S_SEARCH);
	assign cmd.commit  = (state_q == S_COMMIT);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted request did not raise busy");

	a_search_then_commit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SEARCH |=> state_q == S_COMMIT)
		else $error("search not followed by commit");

	a_commit_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COMMIT |=> state_q == S_IDLE)
		else $error("commit not followed by idle");

endmodule

FILE: hdl/nfha_datapath.sv
`timescale 1ns / 1ps
module nfha_datapath
	import nfha_pkg::*;
#(
	parameter int TABLE_ENTRIES = 128
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  nfha_cmd_t               cmd,
	input  logic [1:0]              action,
	input  logic [HANDLE_IN_W-1:0]  handle_in,
	output logic                    done,
	output logic [1:0]              status,
	output logic [HANDLE_OUT_W-1:0] handle_out
);

	localparam int IW   = $clog2(TABLE_ENTRIES);
	localparam int HW   = ((IW > HANDLE_IN_W) ? IW : HANDLE_IN_W) + 1;
	localparam int NG   = (TABLE_ENTRIES + GROUP_BITS - 1) / GROUP_BITS;
	localparam int GIW  = (NG > 1) ? $clog2(NG) : 1;
	localparam int PADW = NG * GROUP_BITS;
	localparam int HOW  = (IW > HANDLE_OUT_W) ? IW : HANDLE_OUT_W;

	// table state
	logic [TABLE_ENTRIES-1:0] used_q;
	logic                     lock_mem [TABLE_ENTRIES];
	logic [IW-1:0]            ptr_q;

	// captured request
	logic [1:0]    action_q;
	logic [IW-1:0] hidx_q;
	logic          hrange_q;
	logic          lock_rd_q;

	// search summaries
	logic [NG-1:0]       any_m_s1;
	logic [NG-1:0]       any_a_s1;
	logic [GROUP_IW-1:0] idx_m_s1 [NG];
	logic [GROUP_IW-1:0] idx_a_s1 [NG];

	// result registers
	logic                    done_q;
	logic [1:0]              status_q;
	logic [HANDLE_OUT_W-1:0] handle_q;

	logic [HW-1:0] hin_ext;
	logic [IW-1:0] hin_idx;
	logic          hin_range;

	assign hin_ext   = HW'(handle_in);
	assign hin_idx   = hin_ext[IW-1:0];
	assign hin_range = (hin_ext < HW'(TABLE_ENTRIES));

	// capture the request and read its lock bit
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q  <= action;
			hidx_q    <= hin_idx;
			hrange_q  <= hin_range;
			lock_rd_q <= lock_mem[hin_idx];
		end
	end

	// first level of the find-first tree: lowest free slot per group,
	// once at or above the pointer and once anywhere
	logic [PADW-1:0]     free_pad;
	logic [PADW-1:0]     free_hi;
	logic [NG-1:0]       any_m_d;
	logic [NG-1:0]       any_a_d;
	logic [GROUP_IW-1:0] idx_m_d [NG];
	logic [GROUP_IW-1:0] idx_a_d [NG];

	always_comb begin
		free_pad = '0;
		free_pad[TABLE_ENTRIES-1:0] = ~used_q;
		for (int p = 0; p < PADW; p++) begin
			free_hi[p] = free_pad[p] && (p >= int'(ptr_q));
		end
		for (int g = 0; g < NG; g++) begin
			any_m_d[g] = 1'b0;
			any_a_d[g] = 1'b0;
			idx_m_d[g] = '0;
			idx_a_d[g] = '0;
			for (int b = GROUP_BITS - 1; b >= 0; b--) begin
				if (free_hi[g * GROUP_BITS + b]) begin
					any_m_d[g] = 1'b1;
					idx_m_d[g] = GROUP_IW'(b);
				end
				if (free_pad[g * GROUP_BITS + b]) begin
					any_a_d[g] = 1'b1;
					idx_a_d[g] = GROUP_IW'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.search) begin
			any_m_s1 <= any_m_d;
			any_a_s1 <= any_a_d;
			idx_m_s1 <= idx_m_d;
			idx_a_s1 <= idx_a_d;
		end
	end

	// second level: first group with a free slot, wrapped search as fallback
	logic                found;
	logic [GIW+GROUP_IW-1:0] granted_full;
	logic [IW-1:0]       granted;
	logic [IW-1:0]       ptr_next;
	logic [HOW-1:0]      granted_ext;

	always_comb begin
		logic                found_m;
		logic                found_a;
		logic [GIW+GROUP_IW-1:0] pos_m;
		logic [GIW+GROUP_IW-1:0] pos_a;
		found_m = 1'b0;
		found_a = 1'b0;
		pos_m   = '0;
		pos_a   = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (any_m_s1[g]) begin
				found_m = 1'b1;
				pos_m   = (GIW + GROUP_IW)'(g * GROUP_BITS + int'(idx_m_s1[g]));
			end
			if (any_a_s1[g]) begin
				found_a = 1'b1;
				pos_a   = (GIW + GROUP_IW)'(g * GROUP_BITS + int'(idx_a_s1[g]));
			end
		end
		found        = found_m || found_a;
		granted_full = found_m ? pos_m : pos_a;
	end

	assign granted     = IW'(granted_full);
	assign ptr_next    = (granted == IW'(TABLE_ENTRIES - 1)) ? '0 : granted + 1'b1;
	assign granted_ext = HOW'(granted);

	// commit: decide the outcome and the single lock write
	logic                    handle_ok;
	logic                    set_used;
	logic                    clr_used;
	logic                    lock_we;
	logic                    lock_wd;
	logic [IW-1:0]           lock_wa;
	logic [1:0]              status_d;
	logic [HANDLE_OUT_W-1:0] handle_d;

	assign handle_ok = hrange_q && used_q[hidx_q];

	always_comb begin
		set_used = 1'b0;
		clr_used = 1'b0;
		lock_we  = 1'b0;
		lock_wd  = 1'b0;
		lock_wa  = hidx_q;
		status_d = ST_SUCCESS;
		handle_d = '0;
		case (action_q)
			ACT_ALLOC: begin
				if (found) begin
					set_used = 1'b1;
					lock_we  = 1'b1;
					lock_wa  = granted;
					handle_d = granted_ext[HANDLE_OUT_W-1:0];
				end else begin
					status_d = ST_NO_MORE;
				end
			end
			ACT_RELEASE: begin
				if (handle_ok) begin
					clr_used = 1'b1;
					lock_we  = 1'b1;
				end else begin
					status_d = ST_BAD_HANDLE;
				end
			end
			ACT_LOCK: begin
				if (handle_ok) begin
					lock_we = 1'b1;
					lock_wd = 1'b1;
				end else begin
					status_d = ST_BAD_HANDLE;
				end
			end
			default: begin
				if (!handle_ok) begin
					status_d = ST_BAD_HANDLE;
				end else if (lock_rd_q) begin
					status_d = ST_LOCKED;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && lock_we) begin
			lock_mem[lock_wa] <= lock_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			ptr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
			if (cmd.commit && set_used) begin
				used_q[granted] <= 1'b1;
				ptr_q           <= ptr_next;
			end
			if (cmd.commit && clr_used) begin
				used_q[hidx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= status_d;
			handle_q <= handle_d;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign handle_out = handle_q;

	a_grant_is_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && action_q == ACT_ALLOC && found |-> !used_q[granted])
		else $error("allocate picked a slot already in use");

	a_no_more_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q == ST_NO_MORE |-> &used_q)
		else $error("no-more-handles reported with a free slot");

	a_fail_handle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q != ST_SUCCESS |-> handle_q == '0)
		else $error("nonzero handle on a failed request");

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> int'(ptr_q) < TABLE_ENTRIES)
		else $error("next-fit pointer beyond the table");

endmodule
